// ===== src/btv_pkg.sv =====
// ----------------------------------------------------------------------------
// btv_pkg: shared types and constants of the barometer triplex voter
// Register indexes, reset values, health flag positions, lane result type,
// and the sequencer state type.
// ----------------------------------------------------------------------------
package btv_pkg;

    localparam int MAX_CH = 3;
    localparam int TPS_DEFAULT = 1000000;

    localparam logic [2:0] REG_STALE = 3'd0;
    localparam logic [2:0] REG_AMIN  = 3'd1;
    localparam logic [2:0] REG_AMAX  = 3'd2;
    localparam logic [2:0] REG_RATE  = 3'd3;
    localparam logic [2:0] REG_BAND  = 3'd4;
    localparam logic [2:0] REG_REJ   = 3'd5;
    localparam logic [2:0] REG_REC   = 3'd6;

    localparam logic [23:0] STALE_RST = 24'd200000;
    localparam logic [31:0] AMIN_RST  = 32'hFFF8_5EE0;   // -500000
    localparam logic [31:0] AMAX_RST  = 32'd50000000;
    localparam logic [23:0] RATE_RST  = 24'd200000;
    localparam logic [23:0] BAND_RST  = 24'd10000;
    localparam logic [15:0] REJ_RST   = 16'd5;
    localparam logic [15:0] REC_RST   = 16'd20;

    localparam int F_INVALID  = 0;
    localparam int F_STALE    = 1;
    localparam int F_RANGE    = 2;
    localparam int F_RATE     = 3;
    localparam int F_DISAGREE = 4;
    localparam int F_REJECTED = 5;

    typedef struct packed {
        logic [23:0] stale_timeout_us;
        logic [31:0] altitude_min_mm;
        logic [31:0] altitude_max_mm;
        logic [23:0] rate_limit_mm_per_s;
        logic [23:0] agree_band_mm;
        logic [15:0] reject_after;
        logic [15:0] recover_after;
    } cfg_t;

    // result of one lane's plausibility check
    typedef struct packed {
        logic       fresh;
        logic [5:0] flags;
    } lane_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_VOTE,
        ST_OUT
    } state_t;

endpackage

// ===== src/btv_lane.sv =====
// ----------------------------------------------------------------------------
// btv_lane: per-channel plausibility check and health bookkeeping
// Checks validity, staleness, range and rate; holds the accepted sample and
// the good/bad run counters with reject and recover.
// ----------------------------------------------------------------------------
module btv_lane #(
    parameter int TICKS_PER_SECOND = btv_pkg::TPS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  btv_pkg::cfg_t       cfg,
    input  logic                present,
    input  logic                valid,
    input  logic signed [31:0]  altitude,
    input  logic [47:0]         stamp,
    input  logic [47:0]         now_us,
    input  logic                check_en,   // stage 1 register, first half
    input  logic                rate_en,    // stage 2 decide and commit
    input  logic                judge_en,
    input  logic                agrees_cons,
    input  logic                vvalid,
    input  logic signed [31:0]  voted,
    input  logic                allow_reject,
    output btv_pkg::lane_res_t  res,
    output logic                healthy,
    output logic                rejected
);
    import btv_pkg::*;

    localparam logic [31:0] TPS = 32'(TICKS_PER_SECOND);

    logic        known_reg;
    logic signed [31:0] acc_alt_reg;
    logic [47:0] acc_stamp_reg;
    logic        rej_reg, rej_next;
    logic [15:0] good_reg, good_next, bad_reg, bad_next;
    logic [47:0] judged_reg;

    // stage 1 registers
    logic        pre_fail_reg, pre_fail_next;
    logic [5:0]  pre_flags_reg, pre_flags_next;
    logic        later_reg;
    logic [32:0] dalt;
    logic [47:0] age;
    logic        stale, range_bad;
    // stage 2 products
    logic [64:0] lhs_reg;
    logic [71:0] rhs_reg;
    logic [5:0]  flags_reg, flags_next;
    logic        fresh_reg, fresh_next;
    logic        take_sample;
    logic        judge_hit;
    logic        over;

    assign age = (now_us >= stamp) ? now_us - stamp : '0;
    assign stale = age > 48'(cfg.stale_timeout_us);
    assign range_bad = (altitude < $signed(cfg.altitude_min_mm))
                    || (altitude > $signed(cfg.altitude_max_mm));
    assign dalt = (altitude >= acc_alt_reg)
                ? 33'({altitude[31], altitude} - {acc_alt_reg[31], acc_alt_reg})
                : 33'({acc_alt_reg[31], acc_alt_reg} - {altitude[31], altitude});

    always_comb begin
        pre_flags_next = '0;
        pre_fail_next  = 1'b1;
        if (!valid) begin
            pre_flags_next[F_INVALID] = 1'b1;
        end else if (stale) begin
            pre_flags_next[F_STALE] = 1'b1;
        end else if (range_bad) begin
            pre_flags_next[F_RANGE] = 1'b1;
        end else begin
            pre_fail_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (check_en) begin
            pre_flags_reg <= pre_flags_next;
            pre_fail_reg  <= pre_fail_next;
            later_reg     <= known_reg && (stamp > acc_stamp_reg);
            // products over two 32-bit-ish multipliers, registered
            lhs_reg <= 65'(dalt) * 65'(TPS);
            rhs_reg <= 72'(cfg.rate_limit_mm_per_s) * 72'(stamp - acc_stamp_reg);
        end
    end

    assign over = later_reg && (72'(lhs_reg) > rhs_reg);
    assign judge_hit = judge_en && fresh_reg && (stamp > judged_reg);

    always_comb begin
        flags_next  = flags_reg;
        fresh_next  = fresh_reg;
        take_sample = 1'b0;
        if (rate_en) begin
            flags_next = '0;
            fresh_next = 1'b0;
            if (present) begin
                flags_next = pre_flags_reg;
                if (!pre_fail_reg) begin
                    if (over) begin
                        flags_next[F_RATE] = 1'b1;
                    end else begin
                        fresh_next = 1'b1;
                        flags_next[F_REJECTED] = rej_reg;
                        take_sample = !known_reg || (stamp > acc_stamp_reg);
                    end
                end
            end
        end else if (judge_hit) begin
            flags_next[F_DISAGREE] = !agrees_cons;
            // keep a rejected mark seen at check time even if the channel recovers
            flags_next[F_REJECTED] = flags_reg[F_REJECTED] | rej_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            known_reg <= 1'b0;
            fresh_reg <= 1'b0;
            flags_reg <= '0;
        end else begin
            fresh_reg <= fresh_next;
            flags_reg <= flags_next;
            if (take_sample) known_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_sample) begin
            acc_alt_reg   <= altitude;
            acc_stamp_reg <= stamp;
        end
    end

    // run counters
    logic        agrees;
    logic [32:0] vdiff;
    logic [15:0] rec_th, rej_th;
    logic [15:0] g_inc, b_inc;
    assign vdiff = (altitude >= voted)
                 ? 33'({altitude[31], altitude} - {voted[31], voted})
                 : 33'({voted[31], voted} - {altitude[31], altitude});
    assign agrees = (rej_reg && vvalid) ? (vdiff <= 33'(cfg.agree_band_mm)) : agrees_cons;
    assign rec_th = (cfg.recover_after == '0) ? 16'd1 : cfg.recover_after;
    assign rej_th = (cfg.reject_after == '0) ? 16'd1 : cfg.reject_after;
    assign g_inc = (good_reg == 16'hFFFF) ? good_reg : good_reg + 16'd1;
    assign b_inc = (bad_reg == 16'hFFFF) ? bad_reg : bad_reg + 16'd1;

    always_comb begin
        good_next = good_reg;
        bad_next  = bad_reg;
        rej_next  = rej_reg;
        if (agrees) begin
            bad_next  = '0;
            good_next = g_inc;
            if (rej_reg && g_inc >= rec_th) begin
                rej_next  = 1'b0;
                good_next = '0;
            end
        end else begin
            good_next = '0;
            bad_next  = b_inc;
            if (allow_reject && !rej_reg && b_inc >= rej_th) begin
                rej_next = 1'b1;
                bad_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rej_reg    <= 1'b0;
            good_reg   <= '0;
            bad_reg    <= '0;
            judged_reg <= '0;
        end else if (judge_hit) begin
            rej_reg    <= rej_next;
            good_reg   <= good_next;
            bad_reg    <= bad_next;
            judged_reg <= stamp;
        end
    end

    assign res.fresh = fresh_reg;
    assign res.flags = flags_reg;
    assign healthy = fresh_reg && !rej_reg;
    assign rejected = rej_reg;

endmodule

// ===== src/btv_merge.sv =====
// ----------------------------------------------------------------------------
// btv_merge: vote across lanes
// Median compare, consensus mask, sum and latest stamp of agreeing lanes.
// ----------------------------------------------------------------------------
module btv_merge (
    input  logic                aclk,
    input  logic                en,
    input  logic [2:0]          healthy,
    input  logic signed [31:0]  alt0,
    input  logic signed [31:0]  alt1,
    input  logic signed [31:0]  alt2,
    input  logic [47:0]         stamp0,
    input  logic [47:0]         stamp1,
    input  logic [47:0]         stamp2,
    input  logic [23:0]         band,
    output logic [2:0]          cons_mask,
    output logic                disagree,
    output logic signed [33:0]  sum,
    output logic [47:0]         vstamp,
    output logic                allow_reject
);
    import btv_pkg::*;

    logic signed [31:0] mid, lo, hi;
    logic [32:0] d01, d0m, d1m, d2m;
    logic [2:0]  cons, near;
    logic        dis;
    logic [1:0]  hcount;
    logic signed [33:0] s;
    logic [47:0] st;

    function automatic logic [32:0] adiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
        logic signed [32:0] x;
        x = 33'(a) - 33'(b);
        return x[32] ? 33'(-x) : 33'(x);
    endfunction

    always_comb begin
        lo = (alt0 < alt1) ? alt0 : alt1;
        hi = (alt0 < alt1) ? alt1 : alt0;
        mid = (alt2 < lo) ? lo : ((alt2 > hi) ? hi : alt2);
        hcount = 2'(healthy[0]) + 2'(healthy[1]) + 2'(healthy[2]);
        d0m = adiff(alt0, mid);
        d1m = adiff(alt1, mid);
        d2m = adiff(alt2, mid);
        near = {d2m <= 33'(band), d1m <= 33'(band), d0m <= 33'(band)};
        d01 = healthy[0] ? (healthy[1] ? adiff(alt0, alt1) : adiff(alt0, alt2))
                         : adiff(alt1, alt2);
        cons = '0;
        dis  = 1'b0;
        unique case (hcount)
            2'd1: cons = healthy;
            2'd2: begin
                if (d01 <= 33'(band)) cons = healthy;
                else dis = 1'b1;
            end
            2'd3: begin
                cons = near;
                dis  = !(&near);
                if (near == 3'b001 || near == 3'b010 || near == 3'b100 || near == 3'b000)
                    cons = '0;
            end
            default: cons = '0;
        endcase
        s = (cons[0] ? 34'(alt0) : 34'sd0) + (cons[1] ? 34'(alt1) : 34'sd0)
          + (cons[2] ? 34'(alt2) : 34'sd0);
        st = '0;
        if (cons[0] && stamp0 > st) st = stamp0;
        if (cons[1] && stamp1 > st) st = stamp1;
        if (cons[2] && stamp2 > st) st = stamp2;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cons_mask    <= cons;
            disagree     <= dis;
            sum          <= s;
            vstamp       <= st;
            allow_reject <= (hcount == 2'd3);
        end
    end

endmodule

// ===== src/barometer_triplex_voter_unit.sv =====
// ----------------------------------------------------------------------------
// barometer_triplex_voter_unit: triplex barometer voter with fault isolation
//
//   channel  | direction | handshake          | carries
//   s_       | in        | s_valid / s_ready  | frame: time and three samples
//   m_       | out       | m_valid / m_ready  | voted altitude and health
//   apb      | in        | psel/penable/...   | seven config registers
//
// The result follows the accept edge through these steps: lane checks and rate
// products in the accept cycle, rate compare, vote, average and health update,
// then the health flags land in the output register. One item is worked on at
// a time and a new one is accepted from the cycle after the previous one is
// judged; a result held by m_ready stalls the next item in its last stage and
// the input with it. Reset is synchronous, clears all channel health state and
// restores the configuration defaults.
// ----------------------------------------------------------------------------
module barometer_triplex_voter_unit #(
    parameter int CHANNELS         = btv_pkg::MAX_CH,
    parameter int TICKS_PER_SECOND = btv_pkg::TPS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [47:0] s_now_us,
    input  logic [1:0]  s_channel_count,
    input  logic        s_valid_0,
    input  logic signed [31:0] s_altitude_0,
    input  logic [47:0] s_stamp_0,
    input  logic        s_valid_1,
    input  logic signed [31:0] s_altitude_1,
    input  logic [47:0] s_stamp_1,
    input  logic        s_valid_2,
    input  logic signed [31:0] s_altitude_2,
    input  logic [47:0] s_stamp_2,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_voted_valid,
    output logic signed [31:0] m_voted_altitude,
    output logic [47:0] m_voted_stamp,
    output logic [2:0]  m_usable_mask,
    output logic [2:0]  m_excluded_mask,
    output logic        m_disagree_seen,
    output logic        m_single_source,
    output logic [5:0]  m_health_0,
    output logic [5:0]  m_health_1,
    output logic [5:0]  m_health_2
);
    import btv_pkg::*;

    cfg_t cfg_reg;
    logic [2:0] reg_idx;
    assign pready = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stale_timeout_us    <= STALE_RST;
            cfg_reg.altitude_min_mm     <= AMIN_RST;
            cfg_reg.altitude_max_mm     <= AMAX_RST;
            cfg_reg.rate_limit_mm_per_s <= RATE_RST;
            cfg_reg.agree_band_mm       <= BAND_RST;
            cfg_reg.reject_after        <= REJ_RST;
            cfg_reg.recover_after       <= REC_RST;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (reg_idx)
                REG_STALE: cfg_reg.stale_timeout_us    <= pwdata[23:0];
                REG_AMIN:  cfg_reg.altitude_min_mm     <= pwdata;
                REG_AMAX:  cfg_reg.altitude_max_mm     <= pwdata;
                REG_RATE:  cfg_reg.rate_limit_mm_per_s <= pwdata[23:0];
                REG_BAND:  cfg_reg.agree_band_mm       <= pwdata[23:0];
                REG_REJ:   cfg_reg.reject_after        <= pwdata[15:0];
                REG_REC:   cfg_reg.recover_after       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STALE: prdata = 32'(cfg_reg.stale_timeout_us);
            REG_AMIN:  prdata = cfg_reg.altitude_min_mm;
            REG_AMAX:  prdata = cfg_reg.altitude_max_mm;
            REG_RATE:  prdata = 32'(cfg_reg.rate_limit_mm_per_s);
            REG_BAND:  prdata = 32'(cfg_reg.agree_band_mm);
            REG_REJ:   prdata = 32'(cfg_reg.reject_after);
            REG_REC:   prdata = 32'(cfg_reg.recover_after);
            default:   prdata = '0;
        endcase
    end

    // sequencer
    state_t state_reg, state_next;
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_fire) state_next = ST_CHECK;
            ST_CHECK: state_next = ST_VOTE;
            ST_VOTE:  state_next = ST_OUT;
            ST_OUT:   if (!m_valid || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic check_en, rate_en, vote_en, judge_en;
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        check_en = s_fire;
        rate_en  = (state_reg == ST_CHECK);
        vote_en  = (state_reg == ST_VOTE);
        judge_en = (state_reg == ST_OUT) && (!m_valid || m_ready);
    end

    // hold the item
    logic [47:0] now_reg;
    logic [2:0]  present_reg;
    logic [2:0]  vbit_reg;
    logic signed [31:0] alt_reg [3];
    logic [47:0] stamp_reg [3];
    logic [1:0]  cnt;
    assign cnt = (32'(s_channel_count) > CHANNELS) ? 2'(CHANNELS) : s_channel_count;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            now_reg     <= s_now_us;
            present_reg <= {cnt > 2'd2, cnt > 2'd1, cnt > 2'd0};
            vbit_reg    <= {s_valid_2, s_valid_1, s_valid_0};
            alt_reg[0]  <= s_altitude_0;
            alt_reg[1]  <= s_altitude_1;
            alt_reg[2]  <= s_altitude_2;
            stamp_reg[0] <= s_stamp_0;
            stamp_reg[1] <= s_stamp_1;
            stamp_reg[2] <= s_stamp_2;
        end
    end

    // lanes see live inputs during accept
    logic signed [31:0] l_alt [3];
    logic [47:0] l_stamp [3];
    logic [2:0]  l_valid;
    logic [47:0] l_now;
    assign l_alt[0] = check_en ? s_altitude_0 : alt_reg[0];
    assign l_alt[1] = check_en ? s_altitude_1 : alt_reg[1];
    assign l_alt[2] = check_en ? s_altitude_2 : alt_reg[2];
    assign l_stamp[0] = check_en ? s_stamp_0 : stamp_reg[0];
    assign l_stamp[1] = check_en ? s_stamp_1 : stamp_reg[1];
    assign l_stamp[2] = check_en ? s_stamp_2 : stamp_reg[2];
    assign l_valid = check_en ? {s_valid_2, s_valid_1, s_valid_0} : vbit_reg;
    assign l_now = check_en ? s_now_us : now_reg;

    lane_res_t   lres [3];
    logic [2:0]  healthy, rejected, cons_mask;
    logic        disagree, allow_rej;
    logic signed [33:0] sum;
    logic [47:0] vstamp;
    logic [1:0]  ncons;
    logic signed [33:0] avg;
    logic signed [31:0] voted;
    logic        vvalid;

    assign ncons = 2'(cons_mask[0]) + 2'(cons_mask[1]) + 2'(cons_mask[2]);
    assign vvalid = (ncons != 2'd0);
    // divide by 1, 2 or 3, truncating toward zero
    logic [33:0] mag;
    logic [67:0] prod3;
    logic [33:0] q;
    assign mag = sum[33] ? 34'(-sum) : 34'(sum);
    // ceil(2^35 / 3) keeps the quotient exact for any 34-bit magnitude
    assign prod3 = 68'(mag) * 68'h2_AAAA_AAAB;
    always_comb begin
        unique case (ncons)
            2'd2: q = mag >> 1;
            2'd3: q = {1'b0, prod3[67:35]};
            default: q = mag;
        endcase
        avg = sum[33] ? -$signed(q) : $signed(q);
    end
    assign voted = vvalid ? 32'(avg) : '0;

    genvar g;
    generate
        for (g = 0; g < MAX_CH; g++) begin : g_lane
            if (g < CHANNELS) begin : g_on
                btv_lane #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_lane (
                    .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
                    .present(present_reg[g]), .valid(l_valid[g]),
                    .altitude(l_alt[g]), .stamp(l_stamp[g]), .now_us(l_now),
                    .check_en(check_en), .rate_en(rate_en),
                    .judge_en(judge_en && present_reg[g]),
                    .agrees_cons(cons_mask[g]), .vvalid(vvalid), .voted(voted),
                    .allow_reject(allow_rej), .res(lres[g]),
                    .healthy(healthy[g]), .rejected(rejected[g])
                );
            end else begin : g_off
                assign lres[g] = '0;
                assign healthy[g] = 1'b0;
                assign rejected[g] = 1'b0;
            end
        end
    endgenerate

    btv_merge u_merge (
        .aclk(aclk), .en(vote_en), .healthy(healthy & present_reg),
        .alt0(alt_reg[0]), .alt1(alt_reg[1]), .alt2(alt_reg[2]),
        .stamp0(stamp_reg[0]), .stamp1(stamp_reg[1]), .stamp2(stamp_reg[2]),
        .band(cfg_reg.agree_band_mm), .cons_mask(cons_mask), .disagree(disagree),
        .sum(sum), .vstamp(vstamp), .allow_reject(allow_rej)
    );

    // results: health flags read from lanes in the cycle after judging
    logic pend_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid  <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            pend_reg <= judge_en;
            if (pend_reg) m_valid <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (judge_en) begin
            m_voted_valid    <= vvalid;
            m_voted_altitude <= voted;
            m_voted_stamp    <= vvalid ? vstamp : '0;
            m_usable_mask    <= cons_mask;
            m_disagree_seen  <= disagree;
            m_single_source  <= (ncons == 2'd1);
        end
        if (pend_reg) begin
            m_excluded_mask <= rejected & present_reg;
            m_health_0 <= lres[0].flags;
            m_health_1 <= lres[1].flags;
            m_health_2 <= lres[2].flags;
        end
    end

endmodule
